// ===== rtl/core/tds_pkg.sv =====
`default_nettype none

package tds_pkg;

  // field widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned HANDLE_W    = 32;
  localparam int unsigned ID_W        = 31;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned TIME_W      = 48;

  // fired words per tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ONESHOT  = 2'd0,
    OP_PERIODIC = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED  = 3'd0,
    KIND_FIRED    = 3'd1,
    KIND_CLEARED  = 3'd2,
    KIND_NOHANDLE = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  // what the scan unit looks for
  typedef enum logic [1:0] {
    SCAN_FREE  = 2'd0,
    SCAN_MATCH = 2'd1,
    SCAN_DUE   = 2'd2
  } scan_mode_e;

  // one timer table entry
  typedef struct packed {
    logic [ID_W-1:0]     ident;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  period;
    logic [TIME_W-1:0]   deadline;
  } slot_entry_t;

  // per-slot flags that go with a candidate into the scan unit
  typedef struct packed {
    logic vld;
    logic active;
    logic done;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/core/tds_slot_mem.sv =====
`default_nettype none

module tds_slot_mem
  import tds_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire slot_entry_t wdata_i,
  input  wire logic        re_i,
  input  wire logic [AW-1:0] raddr_i,
  output slot_entry_t      rdata_o
);

  slot_entry_t mem_q [DEPTH];
  slot_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tds_scan_unit.sv =====
`default_nettype none

module tds_scan_unit
  import tds_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire scan_mode_e        mode_i,
  input  wire cand_t             cand_i,
  input  wire logic [IDX_W-1:0]  cand_idx_i,
  input  wire slot_entry_t       cand_entry_i,
  input  wire logic [TIME_W-1:0] now_i,
  input  wire logic [ID_W-1:0]   match_id_i,
  output logic                   found_o,
  output logic [IDX_W-1:0]       best_idx_o,
  output slot_entry_t            best_o
);

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  slot_entry_t      best_q;
  logic             eligible;
  logic             better;
  logic             take;

  // does the candidate qualify at all
  always_comb begin
    case (mode_i)
      SCAN_FREE:  eligible = !cand_i.active;
      SCAN_MATCH: eligible = cand_i.active && (cand_entry_i.ident == match_id_i);
      SCAN_DUE:   eligible = cand_i.active && !cand_i.done &&
                             (cand_entry_i.deadline <= now_i);
      default:    eligible = 1'b0;
    endcase
  end

  // earliest deadline wins, larger id on ties; other modes keep the first hit
  always_comb begin
    if (!found_q) begin
      better = 1'b1;
    end else if (mode_i == SCAN_DUE) begin
      better = (cand_entry_i.deadline < best_q.deadline) ||
               ((cand_entry_i.deadline == best_q.deadline) &&
                (cand_entry_i.ident > best_q.ident));
    end else begin
      better = 1'b0;
    end
  end

  assign take = cand_i.vld && eligible && better;

  // found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  // best candidate so far
  always_ff @(posedge clk_i) begin
    if (take && !clear_i) begin
      best_q     <= cand_entry_i;
      best_idx_q <= cand_idx_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;

endmodule

`default_nettype wire

// ===== rtl/core/timer_deadline_scheduler_core.sv =====
// Timer deadline scheduler: a table of NUM_TIMERS one-shot and periodic timers.
// Input channel (in_valid_i / in_stall_o) takes one command word: create one-shot,
// create periodic, clear by id, or tick. Output channel (out_valid_o / out_stall_i)
// returns result words; last_o marks the final word caused by one command.
// Only one command is in flight; in_stall_o stays high until its last word has
// been loaded into the output register, or until the scan ends for a tick with
// nothing due, and the next command is taken once the sequencer is idle again.
// Table scans per command:
//   create with zero handle, clear of id 0: no scan
//   create, clear by id: one scan of the table
//   tick: one table scan per fired timer plus a final scan (none after the
//   16th fired timer), no word if none is due
// The scan walks the slot memory one entry per cycle through a single compare
// unit. A tick fires at most 16 timers.
// Reset clears every slot, time to zero and the next id to one; no memory
// clearing pass is needed. When the receiver stalls, the word waits in the
// output register and the sequencer waits before loading the next one.
`default_nettype none

module timer_deadline_scheduler_core
  import tds_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     operation_i,
  input  wire logic [DELAY_W-1:0]  delay_ticks_i,
  input  wire logic [HANDLE_W-1:0] handle_i,
  input  wire logic [ID_W-1:0]     timer_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [KIND_W-1:0]        kind_o,
  output logic [ID_W-1:0]          result_id_o,
  output logic [HANDLE_W-1:0]      result_handle_o,
  output logic                     last_o
);

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_FLUSH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  // control state
  state_e                state_q, state_d;
  state_e                nxt_q, nxt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [NUM_TIMERS-1:0] periodic_q, periodic_d;
  logic [NUM_TIMERS-1:0] done_q, done_d;
  logic [TIME_W-1:0]     now_q, now_d;
  logic [ID_W-1:0]       next_id_q, next_id_d;
  logic [IW-1:0]         lf_slot_q, lf_slot_d;
  logic                  lf_vld_q, lf_vld_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pend_vld_q, pend_vld_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  op_e                   op_q, op_d;
  logic [DELAY_W-1:0]    delay_q, delay_d;
  logic [HANDLE_W-1:0]   handle_q, handle_d;
  logic [ID_W-1:0]       id_q, id_d;
  kind_e                 res_kind_q, res_kind_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic [HANDLE_W-1:0]   res_handle_q, res_handle_d;
  logic                  res_last_q, res_last_d;
  logic [ID_W-1:0]       pend_id_q, pend_id_d;
  logic [HANDLE_W-1:0]   pend_handle_q, pend_handle_d;
  kind_e                 out_kind_q, out_kind_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic [HANDLE_W-1:0]   out_handle_q, out_handle_d;
  logic                  out_last_q, out_last_d;

  // datapath
  logic                  mem_we;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;
  slot_entry_t           mem_wdata;
  slot_entry_t           mem_rdata;
  scan_mode_e            scan_mode;
  cand_t                 cand;
  logic                  scan_clear;
  logic                  found;
  logic [IW-1:0]         best_idx;
  slot_entry_t           best;
  logic                  is_create;
  logic [DELAY_W-1:0]    add_b;
  logic [TIME_W-1:0]     sum;
  logic                  scan_end;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_inc;
  logic [ID_W-1:0]       id_inc;

  // slot memory
  tds_slot_mem #(
    .DEPTH (NUM_TIMERS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (best_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit
  tds_scan_unit #(
    .IDX_W (IW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .mode_i       (scan_mode),
    .cand_i       (cand),
    .cand_idx_i   (rd_idx_q),
    .cand_entry_i (mem_rdata),
    .now_i        (now_q),
    .match_id_i   (id_q),
    .found_o      (found),
    .best_idx_o   (best_idx),
    .best_o       (best)
  );

  // scan mode follows the command
  always_comb begin
    case (op_q)
      OP_ONESHOT, OP_PERIODIC: scan_mode = SCAN_FREE;
      OP_CLEAR:                scan_mode = SCAN_MATCH;
      OP_TICK:                 scan_mode = SCAN_DUE;
      default:                 scan_mode = SCAN_DUE;
    endcase
  end

  assign is_create  = (op_q == OP_ONESHOT) || (op_q == OP_PERIODIC);
  assign mem_re     = (state_q == S_SCAN) && (idx_q < CW'(NUM_TIMERS));
  assign mem_raddr  = idx_q[IW-1:0];
  assign cand.vld    = rd_vld_q && (state_q == S_SCAN);
  assign cand.active = active_q[rd_idx_q];
  assign cand.done   = done_q[rd_idx_q];
  assign scan_clear = (state_q == S_IDLE) || (state_q == S_APPLY);
  assign scan_end   = (state_q == S_SCAN) && rd_vld_q &&
                      (rd_idx_q == IW'(NUM_TIMERS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign id_inc     = next_id_q + ID_W'(1);

  // shared deadline adder: new timer or periodic reload
  assign add_b = is_create ? delay_q : best.period;
  assign sum   = now_q + {{(TIME_W - DELAY_W){1'b0}}, add_b};

  // memory write on create or periodic reload
  assign mem_we = (state_q == S_APPLY) && found &&
                  (is_create || ((op_q == OP_TICK) && periodic_q[best_idx]));

  always_comb begin
    if (is_create) begin
      mem_wdata.ident  = next_id_q;
      mem_wdata.handle = handle_q;
      mem_wdata.period = delay_q;
    end else begin
      mem_wdata.ident  = best.ident;
      mem_wdata.handle = best.handle;
      mem_wdata.period = best.period;
    end
    mem_wdata.deadline = sum;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    nxt_d         = nxt_q;
    idx_d         = '0;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    active_d      = active_q;
    periodic_d    = periodic_q;
    done_d        = done_q;
    now_d         = now_q;
    next_id_d     = next_id_q;
    lf_slot_d     = lf_slot_q;
    lf_vld_d      = lf_vld_q;
    cnt_d         = cnt_q;
    pend_vld_d    = pend_vld_q;
    out_valid_d   = out_valid_q && out_stall_i;
    op_d          = op_q;
    delay_d       = delay_q;
    handle_d      = handle_q;
    id_d          = id_q;
    res_kind_d    = res_kind_q;
    res_id_d      = res_id_q;
    res_handle_d  = res_handle_q;
    res_last_d    = res_last_q;
    pend_id_d     = pend_id_q;
    pend_handle_d = pend_handle_q;
    out_kind_d    = out_kind_q;
    out_id_d      = out_id_q;
    out_handle_d  = out_handle_q;
    out_last_d    = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          delay_d  = delay_ticks_i;
          handle_d = handle_i;
          id_d     = timer_id_i;
          res_id_d     = '0;
          res_handle_d = '0;
          res_last_d   = 1'b1;
          nxt_d        = S_IDLE;
          case (op_e'(operation_i))
            OP_ONESHOT, OP_PERIODIC: begin
              if (handle_i == '0) begin
                res_kind_d = KIND_NOHANDLE;
                state_d    = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: begin
              if (timer_id_i == '0) begin
                // cancel the timer that fired last, if still there
                if (lf_vld_q && active_q[lf_slot_q]) begin
                  active_d[lf_slot_q] = 1'b0;
                end
                res_kind_d = KIND_CLEARED;
                state_d    = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_TICK: begin
              now_d      = now_q + TIME_W'(1);
              done_d     = '0;
              cnt_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // one slot read per cycle, compared in the cycle after its read
        if (mem_re) begin
          idx_d    = idx_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = mem_raddr;
        end else begin
          idx_d = idx_q;
        end
        if (scan_end) begin
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        nxt_d        = S_IDLE;
        res_id_d     = '0;
        res_handle_d = '0;
        res_last_d   = 1'b1;
        case (op_q)
          OP_ONESHOT, OP_PERIODIC: begin
            if (found) begin
              active_d[best_idx]   = 1'b1;
              periodic_d[best_idx] = (op_q == OP_PERIODIC);
              if (lf_vld_q && (lf_slot_q == best_idx)) begin
                lf_vld_d = 1'b0;
              end
              res_kind_d = KIND_CREATED;
              res_id_d   = next_id_q;
              next_id_d  = (id_inc == '0) ? ID_W'(1) : id_inc;
            end else begin
              res_kind_d = KIND_FULL;
            end
            state_d = S_EMIT;
          end
          OP_CLEAR: begin
            if (found) begin
              active_d[best_idx] = 1'b0;
            end
            res_kind_d = KIND_CLEARED;
            state_d    = S_EMIT;
          end
          OP_TICK: begin
            if (found) begin
              // fire: reload or free, hold the word until the next scan tells last
              done_d[best_idx] = 1'b1;
              lf_slot_d        = best_idx;
              lf_vld_d         = 1'b1;
              if (!periodic_q[best_idx]) begin
                active_d[best_idx] = 1'b0;
              end
              cnt_d         = cnt_inc;
              pend_vld_d    = 1'b1;
              pend_id_d     = best.ident;
              pend_handle_d = best.handle;
              res_kind_d    = KIND_FIRED;
              res_id_d      = pend_id_q;
              res_handle_d  = pend_handle_q;
              res_last_d    = 1'b0;
              if (pend_vld_q) begin
                state_d = S_EMIT;
                nxt_d   = (cnt_inc == CNT_W'(MAX_RESULTS)) ? S_FLUSH : S_SCAN;
              end else begin
                state_d = (cnt_inc == CNT_W'(MAX_RESULTS)) ? S_FLUSH : S_SCAN;
              end
            end else if (pend_vld_q) begin
              res_kind_d   = KIND_FIRED;
              res_id_d     = pend_id_q;
              res_handle_d = pend_handle_q;
              pend_vld_d   = 1'b0;
              state_d      = S_EMIT;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_FLUSH: begin
        // tick hit the per-tick limit: send the held word as the last one
        res_kind_d   = KIND_FIRED;
        res_id_d     = pend_id_q;
        res_handle_d = pend_handle_q;
        res_last_d   = 1'b1;
        pend_vld_d   = 1'b0;
        nxt_d        = S_IDLE;
        state_d      = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = res_kind_q;
          out_id_d     = res_id_q;
          out_handle_d = res_handle_q;
          out_last_d   = res_last_q;
          state_d      = nxt_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nxt_q       <= S_IDLE;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      active_q    <= '0;
      periodic_q  <= '0;
      done_q      <= '0;
      now_q       <= '0;
      next_id_q   <= ID_W'(1);
      lf_slot_q   <= '0;
      lf_vld_q    <= 1'b0;
      cnt_q       <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_q       <= nxt_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      active_q    <= active_d;
      periodic_q  <= periodic_d;
      done_q      <= done_d;
      now_q       <= now_d;
      next_id_q   <= next_id_d;
      lf_slot_q   <= lf_slot_d;
      lf_vld_q    <= lf_vld_d;
      cnt_q       <= cnt_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    delay_q       <= delay_d;
    handle_q      <= handle_d;
    id_q          <= id_d;
    res_kind_q    <= res_kind_d;
    res_id_q      <= res_id_d;
    res_handle_q  <= res_handle_d;
    res_last_q    <= res_last_d;
    pend_id_q     <= pend_id_d;
    pend_handle_q <= pend_handle_d;
    out_kind_q    <= out_kind_d;
    out_id_q      <= out_id_d;
    out_handle_q  <= out_handle_d;
    out_last_q    <= out_last_d;
  end

  // ports
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign result_id_o     = out_id_q;
  assign result_handle_o = out_handle_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// ===== verif/tb_timer_deadline_scheduler_core.sv =====
module tb_timer_deadline_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int HALF_PERIOD    = 10;
  localparam int RANDOM_ITEMS   = 84;
  // worst tick: a scan per fired timer plus a closing scan
  localparam int SETTLE_CYCLES  = (NUM_SLOTS + 1) * (NUM_SLOTS + 3) + 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // one result word as the block returns it
  typedef struct packed {
    kind_e               kind;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } result_word_t;

  // one directed command, with its word typed in where it is obvious
  typedef struct {
    op_e                 op;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    bit                  typed;
    kind_e               kind;
    logic [ID_W-1:0]     rid;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i = '0;
  logic [DELAY_W-1:0]  delay_ticks_i = '0;
  logic [HANDLE_W-1:0] handle_i = '0;
  logic [ID_W-1:0]     timer_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [ID_W-1:0]     result_id_o;
  logic [HANDLE_W-1:0] result_handle_o;
  logic                last_o;

  // timer table as the block should hold it
  bit                  tmr_active [NUM_SLOTS];
  bit                  tmr_periodic [NUM_SLOTS];
  logic [ID_W-1:0]     tmr_ident [NUM_SLOTS];
  logic [HANDLE_W-1:0] tmr_handle [NUM_SLOTS];
  logic [DELAY_W-1:0]  tmr_period [NUM_SLOTS];
  logic [TIME_W-1:0]   tmr_deadline [NUM_SLOTS];
  logic [TIME_W-1:0]   now_ticks;
  logic [ID_W-1:0]     next_id;
  int                  last_fired_idx;
  bit                  last_fired_ok;

  result_word_t        fresh_words[$];
  result_word_t        pending_results[$];
  script_row_t         script_rows[$];

  bit                  idle_on = 1'b1;
  int                  stall_run = 0;
  int                  quiet_cycles = 0;
  int                  error_count = 0;
  int                  commands_sent = 0;
  int                  words_checked = 0;
  int                  created_seen = 0;
  int                  fired_seen = 0;
  int                  refused_seen = 0;

  timer_deadline_scheduler_core #(
    .NUM_TIMERS(NUM_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .delay_ticks_i  (delay_ticks_i),
    .handle_i       (handle_i),
    .timer_id_i     (timer_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .result_id_o    (result_id_o),
    .result_handle_o(result_handle_o),
    .last_o         (last_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // timer table model
  function automatic void clear_table();
    int s;
    for (s = 0; s < NUM_SLOTS; s++) begin
      tmr_active[s]   = 1'b0;
      tmr_periodic[s] = 1'b0;
      tmr_ident[s]    = '0;
      tmr_handle[s]   = '0;
      tmr_period[s]   = '0;
      tmr_deadline[s] = '0;
    end
    now_ticks      = '0;
    next_id        = ID_W'(1);
    last_fired_idx = 0;
    last_fired_ok  = 1'b0;
  endfunction

  function automatic void note_word(kind_e kind, logic [ID_W-1:0] id,
                                    logic [HANDLE_W-1:0] handle);
    fresh_words.push_back('{kind, id, handle, 1'b0});
  endfunction

  function automatic void predict_create(bit periodic, logic [DELAY_W-1:0] delay,
                                         logic [HANDLE_W-1:0] handle);
    int s;
    int slot;
    slot = -1;
    if (handle == '0) begin
      note_word(KIND_NOHANDLE, '0, '0);
      return;
    end
    // lowest free slot wins
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (!tmr_active[s] && slot < 0) slot = s;
    end
    if (slot < 0) begin
      note_word(KIND_FULL, '0, '0);
      return;
    end
    tmr_active[slot]   = 1'b1;
    tmr_periodic[slot] = periodic;
    tmr_ident[slot]    = next_id;
    tmr_handle[slot]   = handle;
    tmr_period[slot]   = delay;
    tmr_deadline[slot] = now_ticks + {{(TIME_W-DELAY_W){1'b0}}, delay};
    if (last_fired_ok && last_fired_idx == slot) last_fired_ok = 1'b0;
    note_word(KIND_CREATED, next_id, '0);
    next_id = next_id + 1'b1;
    if (next_id == '0) next_id = ID_W'(1);
  endfunction

  function automatic void predict_clear(logic [ID_W-1:0] id);
    int s;
    bit hit;
    hit = 1'b0;
    if (id == '0) begin
      if (last_fired_ok && tmr_active[last_fired_idx]) tmr_active[last_fired_idx] = 1'b0;
    end else begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (!hit && tmr_active[s] && tmr_ident[s] == id) begin
          tmr_active[s] = 1'b0;
          hit = 1'b1;
        end
      end
    end
    note_word(KIND_CLEARED, '0, '0);
  endfunction

  function automatic void predict_tick();
    bit done_now [NUM_SLOTS];
    int s;
    int best;
    int n;
    for (s = 0; s < NUM_SLOTS; s++) done_now[s] = 1'b0;
    now_ticks = now_ticks + 1'b1;
    n = 0;
    best = 0;
    while (n < MAX_RESULTS && best >= 0) begin
      // earliest deadline first, newest id first on a tie
      best = -1;
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (tmr_active[s] && !done_now[s] && tmr_deadline[s] <= now_ticks) begin
          if (best < 0 || tmr_deadline[s] < tmr_deadline[best] ||
              (tmr_deadline[s] == tmr_deadline[best] && tmr_ident[s] > tmr_ident[best]))
            best = s;
        end
      end
      if (best >= 0) begin
        done_now[best] = 1'b1;
        note_word(KIND_FIRED, tmr_ident[best], tmr_handle[best]);
        n++;
        last_fired_idx = best;
        last_fired_ok  = 1'b1;
        if (tmr_periodic[best])
          tmr_deadline[best] = now_ticks + {{(TIME_W-DELAY_W){1'b0}}, tmr_period[best]};
        else
          tmr_active[best] = 1'b0;
      end
    end
  endfunction

  function automatic void apply_command(op_e op, logic [DELAY_W-1:0] delay,
                                        logic [HANDLE_W-1:0] handle,
                                        logic [ID_W-1:0] id);
    result_word_t tail;
    fresh_words.delete();
    case (op)
      OP_ONESHOT:  predict_create(1'b0, delay, handle);
      OP_PERIODIC: predict_create(1'b1, delay, handle);
      OP_CLEAR:    predict_clear(id);
      default:     predict_tick();
    endcase
    // mark the closing word of this command
    if (fresh_words.size() != 0) begin
      tail = fresh_words.pop_back();
      tail.last = 1'b1;
      fresh_words.push_back(tail);
    end
  endfunction

  // an id that is live right now, or zero (the last fired timer) when none is live
  function automatic logic [ID_W-1:0] pick_live_id();
    logic [ID_W-1:0] live[$];
    int s;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (tmr_active[s]) live.push_back(tmr_ident[s]);
    end
    if (live.size() == 0) return '0;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic void add_row(op_e op, logic [DELAY_W-1:0] delay,
                                  logic [HANDLE_W-1:0] handle, logic [ID_W-1:0] id,
                                  bit typed, kind_e kind, logic [ID_W-1:0] rid);
    script_rows.push_back('{op, delay, handle, id, typed, kind, rid});
  endfunction

  function automatic void flag_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // send one command word, with an optional idle burst ahead of it
  task automatic send_command(op_e op, logic [DELAY_W-1:0] delay,
                              logic [HANDLE_W-1:0] handle, logic [ID_W-1:0] id,
                              bit typed, result_word_t typed_word);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    delay_ticks_i <= delay;
    handle_i      <= handle;
    timer_id_i    <= id;
    do @(posedge clk_i); while (in_stall_o);
    commands_sent++;
    apply_command(op, delay, handle, id);
    if (typed) begin
      pending_results.push_back(typed_word);
    end else begin
      foreach (fresh_words[w]) pending_results.push_back(fresh_words[w]);
    end
  endtask

  // hold the sender until every word is back and the block has gone quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (idle_on && $urandom_range(0, 9) == 0) stall_run <= $urandom_range(1, 19);
    end
  end

  // result word check
  always @(posedge clk_i) begin : result_check
    result_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      case (kind_o)
        KIND_CREATED: created_seen++;
        KIND_FIRED:   fired_seen++;
        KIND_NOHANDLE, KIND_FULL: refused_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("word with nothing expected: kind %0d id %0d handle %h last %0d",
                                kind_o, result_id_o, result_handle_o, last_o));
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind || result_id_o !== want.id ||
            result_handle_o !== want.handle || last_o !== want.last)
          flag_mismatch($sformatf(
            "expected kind %0d id %0d handle %h last %0d, got kind %0d id %0d handle %h last %0d",
            want.kind, want.id, want.handle, want.last,
            kind_o, result_id_o, result_handle_o, last_o));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d words still due",
               quiet_cycles, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                  i;
    int                  k;
    int                  roll;
    int                  pick;
    op_e                 op;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    logic [31:0]         raw;
    logic [ID_W-1:0]     id;
    result_word_t        typed_word;

    clear_table();

    // directed script
    add_row(OP_ONESHOT, '1, '0, '1, 1'b1, KIND_NOHANDLE, '0);    // missing handle
    add_row(OP_CLEAR, '0, '0, '0, 1'b1, KIND_CLEARED, '0);       // nothing has fired yet
    add_row(OP_TICK, '0, '0, '0, 1'b0, KIND_CREATED, '0);        // nothing due
    add_row(OP_ONESHOT, '0, '1, '0, 1'b1, KIND_CREATED, 31'd1);  // zero delay
    add_row(OP_PERIODIC, '0, 32'h5A5A_5A5A, '0, 1'b1, KIND_CREATED, 31'd2);
    add_row(OP_TICK, '0, '0, '0, 1'b0, KIND_CREATED, '0);        // tie, newer id first
    add_row(OP_CLEAR, '0, '0, 31'h7FFF_FFFF, 1'b1, KIND_CLEARED, '0); // id not live
    add_row(OP_TICK, '0, '0, '0, 1'b0, KIND_CREATED, '0);        // zero period refires
    for (k = 0; k < NUM_SLOTS - 1; k++)
      add_row((k % 2) ? OP_PERIODIC : OP_ONESHOT, '0, 32'hC0DE_0100 + k, '0,
              1'b1, KIND_CREATED, ID_W'(3 + k));
    add_row(OP_PERIODIC, 32'd5, 32'd1, '0, 1'b1, KIND_FULL, '0); // table full
    add_row(OP_TICK, '0, '0, '0, 1'b0, KIND_CREATED, '0);        // whole table fires
    add_row(OP_CLEAR, '0, '0, '0, 1'b1, KIND_CLEARED, '0);       // cancel last fired

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_rows[r]) begin
      typed_word = '{script_rows[r].kind, script_rows[r].rid, '0, 1'b1};
      send_command(script_rows[r].op, script_rows[r].delay, script_rows[r].handle,
                   script_rows[r].id, script_rows[r].typed, typed_word);
    end
    drain_results();

    // random traffic, mostly small delays so timers keep firing
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on <= (i < 30) || (i >= 45 && i < 65);
      if (i == 45) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 22)
        op = OP_ONESHOT;
      else if (roll < 42)
        op = OP_PERIODIC;
      else if (roll < 60)
        op = OP_CLEAR;
      else
        op = OP_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 7)
        delay = $urandom_range(0, 6);
      else if (pick < 9)
        delay = $urandom_range(0, 40);
      else
        delay = $urandom;
      handle = ($urandom_range(0, 11) == 0) ? '0 : $urandom;
      raw = $urandom;
      id = raw[ID_W-1:0];
      if (op == OP_CLEAR) begin
        pick = $urandom_range(0, 9);
        if (pick < 3)
          id = '0;
        else if (pick < 8)
          id = pick_live_id();
      end
      send_command(op, delay, handle, id, 1'b0, '0);
    end
    drain_results();

    $display("ran %0d commands and checked %0d result words", commands_sent, words_checked);
    $display("  %0d timers created, %0d fired, %0d creates refused, %0d mismatches",
             created_seen, fired_seen, refused_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tds_pkg.sv
rtl/core/tds_slot_mem.sv
rtl/core/tds_scan_unit.sv
rtl/core/timer_deadline_scheduler_core.sv
verif/tb_timer_deadline_scheduler_core.sv
